### design/pidc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_pkg - shared types and constants for the clamped PID controller
// Item, result and configuration beat layouts, register indices and the
// fixed-point format of the gains.
// ----------------------------------------------------------------------------
package pidc_pkg;

    // Fixed-point position of the Q8.8 gains
    localparam int GAIN_FRAC_BITS = 8;

    localparam int ERR_W   = 16;
    localparam int GAIN_W  = 16;
    localparam int LIMIT_W = 15;
    localparam int DRIVE_W = 16;
    localparam int DIFF_W  = ERR_W + 1;
    localparam int REG_W   = 3;

    localparam int DEF_QUEUE_DEPTH = 4;

    // Item kinds
    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_CLEAR  = 1'b1;

    // Register indices
    localparam logic [REG_W-1:0] REG_GAIN_P    = 3'd0;
    localparam logic [REG_W-1:0] REG_GAIN_I    = 3'd1;
    localparam logic [REG_W-1:0] REG_GAIN_D    = 3'd2;
    localparam logic [REG_W-1:0] REG_INT_LIMIT = 3'd3;
    localparam logic [REG_W-1:0] REG_OUT_MAX   = 3'd4;

    localparam logic [LIMIT_W-1:0] RST_INT_LIMIT = 15'd100;
    localparam logic [DRIVE_W-1:0] RST_OUT_MAX   = 16'd10000;

    typedef struct packed {
        logic                     kind;
        logic signed [ERR_W-1:0]  error_in;
    } t_in_item;

    typedef struct packed {
        logic [DRIVE_W-1:0] drive_out;
    } t_out_item;

    typedef struct packed {
        logic [REG_W-1:0]  reg_idx;
        logic [15:0]       wdata;
    } t_cfg_wr;

    // Work handed from the front end to the back end
    typedef struct packed {
        logic signed [ERR_W-1:0]  err;
        logic signed [ERR_W-1:0]  integ;
        logic signed [DIFF_W-1:0] diff;
    } t_job;

endpackage

### design/pidc_chan_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_chan_if - valid/ready channel
// Carries one beat of payload type T per valid and ready handshake.
// ----------------------------------------------------------------------------
interface pidc_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/pidc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_front - item intake and controller state
// Takes input beats, applies clear items, updates the saturating integral
// and the previous error, and queues sample work for the back end.
// ----------------------------------------------------------------------------
module pidc_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  pidc_pkg::t_in_item                  i_in_data,
    output logic                                o_in_ready,
    input  logic [pidc_pkg::LIMIT_W-1:0]        i_int_limit,
    input  logic                                i_q_full,
    output logic                                o_push,
    output pidc_pkg::t_job                      o_job
);
    import pidc_pkg::*;

    logic signed [ERR_W-1:0]  r_integ, n_integ;
    logic signed [ERR_W-1:0]  r_last,  n_last;
    logic signed [ERR_W:0]    acc_raw;
    logic signed [ERR_W:0]    lim_pos;
    logic signed [ERR_W:0]    lim_neg;
    logic signed [ERR_W:0]    acc_sat;
    logic                     accept;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;

    assign acc_raw = {r_integ[ERR_W-1], r_integ} + {i_in_data.error_in[ERR_W-1], i_in_data.error_in};
    assign lim_pos = {2'b00, i_int_limit};
    assign lim_neg = -lim_pos;

    always_comb begin
        if (acc_raw > lim_pos) begin
            acc_sat = lim_pos;
        end else if (acc_raw < lim_neg) begin
            acc_sat = lim_neg;
        end else begin
            acc_sat = acc_raw;
        end
    end

    always_comb begin
        n_integ = r_integ;
        n_last  = r_last;
        if (accept) begin
            if (i_in_data.kind == KIND_CLEAR) begin
                n_integ = '0;
                n_last  = '0;
            end else begin
                n_integ = acc_sat[ERR_W-1:0];
                n_last  = i_in_data.error_in;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integ <= '0;
            r_last  <= '0;
        end else begin
            r_integ <= n_integ;
            r_last  <= n_last;
        end
    end

    assign o_push      = accept && (i_in_data.kind == KIND_SAMPLE);
    assign o_job.err   = i_in_data.error_in;
    assign o_job.integ = acc_sat[ERR_W-1:0];
    assign o_job.diff  = {i_in_data.error_in[ERR_W-1], i_in_data.error_in}
                       - {r_last[ERR_W-1], r_last};

endmodule

### design/pidc_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_queue - short job queue
// Circular buffer that decouples the front end from the back end.
// ----------------------------------------------------------------------------
module pidc_queue #(
    parameter int DEPTH = pidc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  pidc_pkg::t_job  i_job,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output pidc_pkg::t_job  o_job
);
    import pidc_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_job            r_mem [DEPTH];
    logic [AW-1:0]   r_wptr, n_wptr;
    logic [AW-1:0]   r_rptr, n_rptr;
    logic [CW-1:0]   r_cnt,  n_cnt;
    logic            do_push;
    logic            do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_comb begin
        n_wptr = r_wptr;
        n_rptr = r_rptr;
        n_cnt  = r_cnt;
        if (do_push) begin
            n_wptr = (r_wptr == AW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
        end
        if (do_pop) begin
            n_rptr = (r_rptr == AW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wptr] <= i_job;
        end
    end

endmodule

### design/pidc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pidc_back - gain products, scaling and output clamp
// Stage 1 forms the three gain products, stage 2 sums, rescales and clamps
// into the output register.
// ----------------------------------------------------------------------------
module pidc_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  pidc_pkg::t_job                      i_job,
    output logic                                o_pop,
    input  logic signed [pidc_pkg::GAIN_W-1:0]  i_gain_p,
    input  logic signed [pidc_pkg::GAIN_W-1:0]  i_gain_i,
    input  logic signed [pidc_pkg::GAIN_W-1:0]  i_gain_d,
    input  logic [pidc_pkg::DRIVE_W-1:0]        i_out_max,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic [pidc_pkg::DRIVE_W-1:0]        o_drive
);
    import pidc_pkg::*;

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PD_W  = GAIN_W + DIFF_W;
    localparam int SUM_W = PD_W + 2;

    logic                     r_s1_vld;
    logic signed [PP_W-1:0]   r_prod_p;
    logic signed [PP_W-1:0]   r_prod_i;
    logic signed [PD_W-1:0]   r_prod_d;
    logic                     r_out_vld;
    logic [DRIVE_W-1:0]       r_drive, n_drive;

    logic                     out_en;
    logic                     s1_en;
    logic signed [SUM_W-1:0]  sum;
    logic signed [SUM_W-1:0]  scaled;
    logic signed [SUM_W-1:0]  max_ext;

    assign out_en = !r_out_vld || i_out_ready;
    assign s1_en  = !r_s1_vld || out_en;
    assign o_pop  = i_q_valid && s1_en;

    always_ff @(posedge i_clk) begin
        if (s1_en) begin
            r_prod_p <= i_gain_p * i_job.err;
            r_prod_i <= i_gain_i * i_job.integ;
            r_prod_d <= i_gain_d * i_job.diff;
        end
    end

    assign sum = SUM_W'(r_prod_p) + SUM_W'(r_prod_i) + SUM_W'(r_prod_d);
    // arithmetic shift gives floor division by the gain scale
    assign scaled  = sum >>> GAIN_FRAC_BITS;
    assign max_ext = $signed({{(SUM_W - DRIVE_W){1'b0}}, i_out_max});

    always_comb begin
        if (scaled[SUM_W-1]) begin
            n_drive = '0;
        end else if (scaled > max_ext) begin
            n_drive = i_out_max;
        end else begin
            n_drive = scaled[DRIVE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_vld) begin
            r_drive <= n_drive;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (s1_en) begin
                r_s1_vld <= i_q_valid;
            end
            if (out_en) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_drive     = r_drive;

endmodule

### design/pid_controller_clamped_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pid_controller_clamped_top - discrete PID controller, clamped integral
// Q8.8 gains on error, saturating integral and error difference; the scaled
// sum is clamped to the range 0 .. output_max.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Payload                     Beat meaning
//  i_in     in   kind, error_in              sample (kind 0) or clear (kind 1)
//  o_out    out  drive_out                   one result per sample beat
//  i_cfg    in   reg_idx, wdata              register write, idx > 4 ignored
//
//  One item per cycle when not stalled. A sample beat updates the integral
//  and the previous error in the cycle it is taken; its result goes through
//  the queue, the product stage and the sum/clamp output register. Clear
//  beats give no result. The front end stalls only when the job queue is
//  full; the back end stalls only on o_out backpressure. Synchronous
//  active-low reset clears the state, the queue and the pipeline valids and
//  loads register defaults. The configuration channel is always ready.
//
module pid_controller_clamped_top #(
    parameter int QUEUE_DEPTH = pidc_pkg::DEF_QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pidc_chan_if.sink   i_in,
    pidc_chan_if.source o_out,
    pidc_chan_if.sink   i_cfg
);
    import pidc_pkg::*;

    // configuration registers
    logic signed [GAIN_W-1:0] r_gain_p;
    logic signed [GAIN_W-1:0] r_gain_i;
    logic signed [GAIN_W-1:0] r_gain_d;
    logic [LIMIT_W-1:0]       r_int_limit;
    logic [DRIVE_W-1:0]       r_out_max;

    logic   push;
    t_job   push_job;
    logic   q_full;
    logic   q_valid;
    t_job   q_job;
    logic   pop;
    logic   out_valid;
    logic [DRIVE_W-1:0] drive;
    t_cfg_wr cfg;

    assign i_cfg.ready = 1'b1;
    assign cfg         = i_cfg.data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain_p    <= '0;
            r_gain_i    <= '0;
            r_gain_d    <= '0;
            r_int_limit <= RST_INT_LIMIT;
            r_out_max   <= RST_OUT_MAX;
        end else if (i_cfg.valid) begin
            case (cfg.reg_idx)
                REG_GAIN_P:    r_gain_p    <= cfg.wdata;
                REG_GAIN_I:    r_gain_i    <= cfg.wdata;
                REG_GAIN_D:    r_gain_d    <= cfg.wdata;
                REG_INT_LIMIT: r_int_limit <= cfg.wdata[LIMIT_W-1:0];
                REG_OUT_MAX:   r_out_max   <= cfg.wdata;
                default: begin
                end
            endcase
        end
    end

    // front end: intake, clears and integral state
    pidc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_data   (i_in.data),
        .o_in_ready  (i_in.ready),
        .i_int_limit (r_int_limit),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_job       (push_job)
    );

    pidc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    // back end: multiply, scale, clamp
    pidc_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (q_job),
        .o_pop       (pop),
        .i_gain_p    (r_gain_p),
        .i_gain_i    (r_gain_i),
        .i_gain_d    (r_gain_d),
        .i_out_max   (r_out_max),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_drive     (drive)
    );

    assign o_out.valid          = out_valid;
    assign o_out.data.drive_out = drive;

endmodule
